/* hw/rtl/cps_pkg.sv */
// Shared constants for the closed-polygon corner-cutting smoother.
// No dependencies; every other file in hw/rtl depends on this package.
`default_nettype none

package cps_pkg;

  // Default coordinate width of the vertex and point channels.
  localparam int COORD_BITS_DEF = 32;

  // Width and reset value of the pass count register.
  localparam int PASS_W = 2;
  localparam logic [PASS_W-1:0] PASS_COUNT_RST = PASS_W'(2);

  // Vertex counter width; the count saturates at three.
  localparam int SEEN_W = 2;

  // Pass-one points produced by one vertex: the edge to the previous vertex
  // and, on the final vertex, the closing edge.
  localparam int FEED_PTS = 4;

  // Most points that one vertex can produce, and the width of a point count.
  localparam int MAX_PTS = 10;
  localparam int CNT_W   = $clog2(MAX_PTS + 1);

endpackage

`default_nettype wire

/* hw/rtl/cps_ifs.sv */
// Valid/ready channel interfaces for the polygon smoother: vertices in, points out.
// Depends on cps_pkg for the default coordinate width.
`default_nettype none

interface cps_vertex_if #(
  parameter int COORD_BITS = cps_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         vertex_last;

  modport source (output valid, vertex_x, vertex_y, vertex_last, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_last, output ready);
endinterface

interface cps_point_if #(
  parameter int COORD_BITS = cps_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         point_final;
  logic                         too_few_vertices;

  modport source (output valid, point_x, point_y, point_final, too_few_vertices,
                  input ready);
  modport sink   (input valid, point_x, point_y, point_final, too_few_vertices,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/chaikin_polygon_smoother.sv */
// Chaikin corner cutting of a closed polygon, one or two passes in cascade.
// A vertex passes the input register, the pass-one result register and the output
// list before its first point shows. Flow: points (four per vertex with two passes,
// two with one) drain one per cycle while point.ready is high; a vertex waits in
// pass one until the list has room for them, unless it produces no point.
// Reset: synchronous, active high; clears the pipeline, the polygon state and
// sets pass_count to two.
`default_nettype none

module chaikin_polygon_smoother #(
  parameter int COORD_BITS = cps_pkg::COORD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_wr_en,
  input  wire logic [cps_pkg::PASS_W-1:0]  cfg_wr_data,
  cps_vertex_if.sink                       vertex,
  cps_point_if.source                      point
);
  import cps_pkg::*;

  localparam int CW = COORD_BITS;

  // floor((3a+b)/4) computed exactly two bits wider, then truncated.
  function automatic logic signed [CW-1:0] blend(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    logic signed [CW+1:0] ae;
    logic signed [CW+1:0] be;
    logic signed [CW+1:0] s;
    ae = (CW+2)'(a);
    be = (CW+2)'(b);
    s  = (ae <<< 1) + ae + be;
    return s[CW+1:2];
  endfunction

  // Configuration register.
  logic [PASS_W-1:0] pass_count;
  logic              two_pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_count <= PASS_COUNT_RST;
    end else if (cfg_wr_en) begin
      pass_count <= cfg_wr_data;
    end
  end

  // Pass counts of two and three both mean two passes.
  assign two_pass = pass_count[1];

  // ---------------------------------------------------------------------------
  // Pipeline control.
  // ---------------------------------------------------------------------------
  logic s0_valid, s1_valid;
  logic s0_adv, s1_adv, s1_free, list_free, list_load;
  logic out_beat;
  logic [CNT_W-1:0] out_cnt;
  logic [CNT_W-1:0] nout;

  assign out_beat  = point.valid && point.ready;
  assign list_free = (out_cnt == '0) || ((out_cnt == CNT_W'(1)) && out_beat);
  assign s1_adv    = s1_valid && ((nout == '0) || list_free);
  assign list_load = s1_adv && (nout != '0);
  assign s1_free   = !s1_valid || s1_adv;
  assign s0_adv    = s0_valid && s1_free;
  assign vertex.ready = !s0_valid || s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (vertex.ready) begin
        s0_valid <= vertex.valid;
      end
      if (s1_free) begin
        s1_valid <= s0_adv;
      end
    end
  end

  // Input register.
  logic signed [CW-1:0] s0_x, s0_y;
  logic                 s0_last;

  always_ff @(posedge clk) begin
    if (vertex.valid && vertex.ready) begin
      s0_x    <= vertex.vertex_x;
      s0_y    <= vertex.vertex_y;
      s0_last <= vertex.vertex_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Pass one: edge from the previous vertex, and the closing edge on the last.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] first_one_x, first_one_y, prev_one_x, prev_one_y;
  logic [SEEN_W-1:0]    vertex_seen;
  logic                 p1_err, p1_edge, p1_close;
  logic signed [CW-1:0] p1_x [FEED_PTS];
  logic signed [CW-1:0] p1_y [FEED_PTS];

  always_comb begin
    p1_err   = s0_last && (vertex_seen < SEEN_W'(2));
    p1_edge  = !p1_err && (vertex_seen != '0);
    p1_close = s0_last && !p1_err;
    p1_x[0]  = blend(prev_one_x, s0_x);
    p1_y[0]  = blend(prev_one_y, s0_y);
    p1_x[1]  = blend(s0_x, prev_one_x);
    p1_y[1]  = blend(s0_y, prev_one_y);
    p1_x[2]  = blend(s0_x, first_one_x);
    p1_y[2]  = blend(s0_y, first_one_y);
    p1_x[3]  = blend(first_one_x, s0_x);
    p1_y[3]  = blend(first_one_y, s0_y);
  end

  // Vertex counter: counts up to three, clears at the end of a polygon.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_seen <= '0;
    end else if (s0_adv) begin
      if (s0_last) begin
        vertex_seen <= '0;
      end else if (vertex_seen != SEEN_W'(3)) begin
        vertex_seen <= vertex_seen + SEEN_W'(1);
      end
    end
  end

  // First and previous vertex of pass one.
  always_ff @(posedge clk) begin
    if (s0_adv && !p1_err) begin
      if (vertex_seen == '0) begin
        first_one_x <= s0_x;
        first_one_y <= s0_y;
      end
      prev_one_x <= s0_x;
      prev_one_y <= s0_y;
    end
  end

  // Pass-one result register.
  logic signed [CW-1:0] s1_x [FEED_PTS];
  logic signed [CW-1:0] s1_y [FEED_PTS];
  logic                 s1_err, s1_edge, s1_close, s1_last;

  always_ff @(posedge clk) begin
    if (s0_adv) begin
      s1_x     <= p1_x;
      s1_y     <= p1_y;
      s1_err   <= p1_err;
      s1_edge  <= p1_edge;
      s1_close <= p1_close;
      s1_last  <= s0_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Pass two and the ordered point list.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] first_two_x, first_two_y, prev_two_x, prev_two_y;
  logic                 second_started;
  logic signed [CW-1:0] fst_x, fst_y;
  logic signed [CW-1:0] raw_x [MAX_PTS];
  logic signed [CW-1:0] raw_y [MAX_PTS];
  logic signed [CW-1:0] nx [MAX_PTS];
  logic signed [CW-1:0] ny [MAX_PTS];

  // Raw slots: edge from the held point, then the three feed-to-feed edges,
  // then the closing edge back to the first pass-two point.
  always_comb begin
    fst_x = second_started ? first_two_x : s1_x[0];
    fst_y = second_started ? first_two_y : s1_y[0];
    raw_x[0] = blend(prev_two_x, s1_x[0]);
    raw_y[0] = blend(prev_two_y, s1_y[0]);
    raw_x[1] = blend(s1_x[0], prev_two_x);
    raw_y[1] = blend(s1_y[0], prev_two_y);
    for (int i = 1; i < FEED_PTS; i++) begin
      raw_x[2*i]   = blend(s1_x[i-1], s1_x[i]);
      raw_y[2*i]   = blend(s1_y[i-1], s1_y[i]);
      raw_x[2*i+1] = blend(s1_x[i], s1_x[i-1]);
      raw_y[2*i+1] = blend(s1_y[i], s1_y[i-1]);
    end
    raw_x[MAX_PTS-2] = blend(s1_x[FEED_PTS-1], fst_x);
    raw_y[MAX_PTS-2] = blend(s1_y[FEED_PTS-1], fst_y);
    raw_x[MAX_PTS-1] = blend(fst_x, s1_x[FEED_PTS-1]);
    raw_y[MAX_PTS-1] = blend(fst_y, s1_y[FEED_PTS-1]);
  end

  // Pick the list and its length: error point, one pass, or two passes.
  always_comb begin
    nx   = raw_x;
    ny   = raw_y;
    nout = '0;
    priority if (s1_err) begin
      nx[0] = '0;
      ny[0] = '0;
      nout  = CNT_W'(1);
    end else if (!two_pass) begin
      for (int i = 0; i < FEED_PTS; i++) begin
        nx[i] = s1_x[i];
        ny[i] = s1_y[i];
      end
      nout = s1_close ? CNT_W'(4) : (s1_edge ? CNT_W'(2) : CNT_W'(0));
    end else begin
      // Without a held point the first edge does not exist: drop two slots.
      if (!second_started) begin
        for (int i = 0; i < MAX_PTS - 2; i++) begin
          nx[i] = raw_x[i+2];
          ny[i] = raw_y[i+2];
        end
      end
      if (s1_edge) begin
        nout = (second_started ? CNT_W'(2) : CNT_W'(0))
             + (s1_close ? CNT_W'(8) : CNT_W'(2));
      end
    end
  end

  // Pass-two start flag: set by the first fed point, cleared per polygon.
  always_ff @(posedge clk) begin
    if (rst) begin
      second_started <= 1'b0;
    end else if (s1_adv) begin
      if (s1_err || s1_last) begin
        second_started <= 1'b0;
      end else if (two_pass && s1_edge) begin
        second_started <= 1'b1;
      end
    end
  end

  // First and previous point of pass two.
  always_ff @(posedge clk) begin
    if (s1_adv && two_pass && s1_edge && !s1_last) begin
      if (!second_started) begin
        first_two_x <= s1_x[0];
        first_two_y <= s1_y[0];
      end
      prev_two_x <= s1_x[1];
      prev_two_y <= s1_y[1];
    end
  end

  // ---------------------------------------------------------------------------
  // Output list: loaded whole, shifted out one beat per cycle while point.ready is high.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] ox [MAX_PTS];
  logic signed [CW-1:0] oy [MAX_PTS];
  logic                 o_final, o_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
    end else if (list_load) begin
      out_cnt <= nout;
    end else if (out_beat) begin
      out_cnt <= out_cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (list_load) begin
      ox      <= nx;
      oy      <= ny;
      o_final <= s1_last || s1_err;
      o_err   <= s1_err;
    end else if (out_beat) begin
      for (int i = 0; i < MAX_PTS - 1; i++) begin
        ox[i] <= ox[i+1];
        oy[i] <= oy[i+1];
      end
    end
  end

  assign point.valid            = (out_cnt != '0);
  assign point.point_x          = ox[0];
  assign point.point_y          = oy[0];
  assign point.point_final      = o_final && (out_cnt == CNT_W'(1));
  assign point.too_few_vertices = o_err;

endmodule

`default_nettype wire
